// File: hw/rtl/cbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbl_pkg: shared definitions for the cascaded biquad low-pass filter
// Coefficient format, register indexes, operation codes and term codes.
// ----------------------------------------------------------------------------
package cbl_pkg;

   // Coefficients are signed Q15 values held in 18 bits.
   localparam int COEF_BITS = 18;
   localparam int FRAC_BITS = 15;
   localparam int CNT_BITS  = $clog2(COEF_BITS);

   // Configuration register indexes.
   localparam logic [1:0] CSR_FEED_0 = 2'd0;
   localparam logic [1:0] CSR_FEED_1 = 2'd1;
   localparam logic [1:0] CSR_BACK_1 = 2'd2;
   localparam logic [1:0] CSR_BACK_2 = 2'd3;

   // Item operation codes.
   localparam logic OP_PRIME  = 1'b0;
   localparam logic OP_FILTER = 1'b1;

   // Section selection.
   localparam logic SEC_FIRST  = 1'b0;
   localparam logic SEC_SECOND = 1'b1;

   // The four product terms of one section, in the order they are summed.
   typedef enum logic [1:0] {
      TERM_FEED_0,
      TERM_FEED_1,
      TERM_BACK_1,
      TERM_BACK_2
   } term_type;

   typedef logic signed [COEF_BITS-1:0] coef_type;

endpackage

// File: hw/rtl/cascaded_biquad_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_biquad_lowpass: two direct-form-1 low-pass biquads in cascade
// Both sections share four Q15 coefficients. Products are formed by one
// serial-parallel multiplier that consumes one coefficient bit per cycle.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | req_operation, req_sample
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_filtered
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
//  A filter item runs from acceptance to the next acceptance through
//  8 products (each an operand load, 18 coefficient bits and a sum), one
//  history update per section and the hand-off; a prime item goes straight
//  to the hand-off. The input is stalled until the hand-off is done.
//  Reset is synchronous and clears coefficients, history and control state.
//  A finished result waits in the output register; the next item is accepted
//  meanwhile, and a later result waits until that register has been taken.

module cascaded_biquad_lowpass
   import cbl_pkg::*;
#(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   // Result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   // Configuration writes
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [COEF_BITS-1:0]          csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type                    state_ff;
   term_type                     term_ff;
   logic                         sec_ff;
   logic [CNT_BITS-1:0]          bit_cnt_ff;
   logic [SAMPLE_BITS-1:0]       x_ff;
   logic [SAMPLE_BITS-1:0]       y_ff;
   logic [SAMPLE_BITS-1:0]       a_ff;
   logic [SAMPLE_BITS:0]         acc_hi_ff;
   logic [2:0]                   lo3_ff;
   logic [COEF_BITS-1:0]         coef_sr_ff;
   logic                         rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]       rsp_filtered_ff;

   coef_type                     coef_ff [4];
   logic [SAMPLE_BITS-1:0]       in_d1_ff  [2];
   logic [SAMPLE_BITS-1:0]       in_d2_ff  [2];
   logic [SAMPLE_BITS-1:0]       out_d1_ff [2];
   logic [SAMPLE_BITS-1:0]       out_d2_ff [2];

   logic                         req_take;
   logic                         out_free;
   logic [SAMPLE_BITS-1:0]       operand_in;
   logic [COEF_BITS-1:0]         coef_in;
   logic [SAMPLE_BITS:0]         a_ext;
   logic [SAMPLE_BITS:0]         addend;
   logic [SAMPLE_BITS:0]         sum;
   logic [SAMPLE_BITS-1:0]       product;
   logic                         last_bit;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // Configuration registers; an index past the list cannot occur.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) coef_ff[i] <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FEED_0: coef_ff[0] <= csr_wdata;
            CSR_FEED_1: coef_ff[1] <= csr_wdata;
            CSR_BACK_1: coef_ff[2] <= csr_wdata;
            CSR_BACK_2: coef_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Operand and coefficient of the next product for the current section.
   always_comb begin
      unique case (term_ff)
         TERM_FEED_0: begin
            operand_in = x_ff + in_d2_ff[sec_ff];
            coef_in    = coef_ff[0];
         end
         TERM_FEED_1: begin
            operand_in = in_d1_ff[sec_ff];
            coef_in    = coef_ff[1];
         end
         TERM_BACK_1: begin
            operand_in = out_d1_ff[sec_ff];
            coef_in    = coef_ff[2];
         end
         TERM_BACK_2: begin
            operand_in = out_d2_ff[sec_ff];
            coef_in    = coef_ff[3];
         end
         default: begin
            operand_in = '0;
            coef_in    = '0;
         end
      endcase
   end

   // One multiplier step: add the operand for a set coefficient bit, the
   // sign bit carrying negative weight, then shift the partial product right.
   assign last_bit = (bit_cnt_ff == CNT_BITS'(COEF_BITS - 1));
   assign a_ext    = {a_ff[SAMPLE_BITS-1], a_ff};
   always_comb begin
      if (!coef_sr_ff[0]) begin
         addend = '0;
      end else if (last_bit) begin
         addend = -a_ext;
      end else begin
         addend = a_ext;
      end
   end
   assign sum = acc_hi_ff + addend;

   // Bits FRAC_BITS and up of the finished product, wrapped to the sample width.
   assign product = {acc_hi_ff[SAMPLE_BITS-4:0], lo3_ff};

   // Sequencer, datapath registers and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_FEED_0;
         sec_ff       <= SEC_FIRST;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  x_ff    <= req_sample;
                  term_ff <= TERM_FEED_0;
                  sec_ff  <= SEC_FIRST;
                  if (req_operation == OP_PRIME) begin
                     y_ff     <= req_sample;
                     state_ff <= ST_DONE;
                  end else begin
                     y_ff     <= '0;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               a_ff       <= operand_in;
               coef_sr_ff <= coef_in;
               acc_hi_ff  <= '0;
               lo3_ff     <= '0;
               bit_cnt_ff <= '0;
               state_ff   <= ST_MUL;
            end
            ST_MUL: begin
               acc_hi_ff  <= {sum[SAMPLE_BITS], sum[SAMPLE_BITS:1]};
               lo3_ff     <= {sum[0], lo3_ff[2:1]};
               coef_sr_ff <= {1'b0, coef_sr_ff[COEF_BITS-1:1]};
               bit_cnt_ff <= bit_cnt_ff + CNT_BITS'(1);
               if (last_bit) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (term_ff == TERM_FEED_0 || term_ff == TERM_FEED_1) begin
                  y_ff <= y_ff + product;
               end else begin
                  y_ff <= y_ff - product;
               end
               if (term_ff == TERM_BACK_2) begin
                  state_ff <= ST_SHIFT;
               end else begin
                  term_ff  <= term_type'(term_ff + 2'd1);
                  state_ff <= ST_LOAD;
               end
            end
            ST_SHIFT: begin
               term_ff <= TERM_FEED_0;
               if (sec_ff == SEC_FIRST) begin
                  x_ff     <= y_ff;
                  y_ff     <= '0;
                  sec_ff   <= SEC_SECOND;
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_filtered_ff <= y_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Section history: loaded with the sample on prime, shifted after a section.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            in_d1_ff[i]  <= '0;
            in_d2_ff[i]  <= '0;
            out_d1_ff[i] <= '0;
            out_d2_ff[i] <= '0;
         end
      end else if (req_take && req_operation == OP_PRIME) begin
         for (int i = 0; i < 2; i++) begin
            in_d1_ff[i]  <= req_sample;
            in_d2_ff[i]  <= req_sample;
            out_d1_ff[i] <= req_sample;
            out_d2_ff[i] <= req_sample;
         end
      end else if (state_ff == ST_SHIFT) begin
         in_d2_ff[sec_ff]  <= in_d1_ff[sec_ff];
         in_d1_ff[sec_ff]  <= x_ff;
         out_d2_ff[sec_ff] <= out_d1_ff[sec_ff];
         out_d1_ff[sec_ff] <= y_ff;
      end
   end

`ifndef NO_ASSERTIONS
   // An accepted item keeps the input side stalled in the following cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("input accepted again straight after an item");

   // The bit counter never runs past the coefficient width while multiplying.
   a_bit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (bit_cnt_ff < CNT_BITS'(COEF_BITS)))
      else $error("multiplier ran past the coefficient width");

   // A result appears only from the hand-off state.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the hand-off state");

   // The first section always hands over to the second.
   a_second_section: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && sec_ff == SEC_FIRST)
         |=> (state_ff == ST_LOAD && sec_ff == SEC_SECOND))
      else $error("first section did not hand over to the second");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the cascaded biquad low-pass filter
// Drives prime and filter items under several coefficient settings, predicts
// every filtered sample bit for bit and checks each result in order, while
// the sender pauses in bursts and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_top
   import cbl_pkg::*;
();

   localparam int SAMPLE_BITS = 32;
   localparam int unsigned PHASE_ITEMS    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned FINAL_CYCLES   = 200;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] Q15_ONE    = 32768;

   localparam coef_type COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam coef_type COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

   // Receiver stall patterns and sample shapes for the random part.
   typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_pattern_type;
   typedef enum logic [1:0] {
      STYLE_WALK, STYLE_NOISE, STYLE_STEP, STYLE_EXTREME
   } sample_style_type;

   // Predicts the filtered output of both sections and checks each result.
   class lowpass_scoreboard;
      coef_type                      coef[4];
      logic signed [SAMPLE_BITS-1:0] in_hist[2][2];
      logic signed [SAMPLE_BITS-1:0] out_hist[2][2];
      logic signed [SAMPLE_BITS-1:0] expected_filtered[$];
      int unsigned                   mismatch_count;
      int unsigned                   prime_count;
      int unsigned                   filter_count;
      int unsigned                   checked_count;

      function new();
         foreach (coef[i]) coef[i] = '0;
         foreach (in_hist[s, t]) begin
            in_hist[s][t]  = '0;
            out_hist[s][t] = '0;
         end
         mismatch_count = 0;
         prime_count    = 0;
         filter_count   = 0;
         checked_count  = 0;
      endfunction

      function void write_coef(logic [1:0] index, coef_type value);
         coef[index] = value;
      endfunction

      // Q15 product: bits FRAC_BITS upwards of the exact signed product.
      function logic signed [SAMPLE_BITS-1:0] scale(logic signed [SAMPLE_BITS-1:0] value,
                                                    coef_type c);
         logic signed [SAMPLE_BITS+COEF_BITS-1:0] product;
         product = value * c;
         return product[FRAC_BITS +: SAMPLE_BITS];
      endfunction

      // One direct-form-1 section; every sum wraps at the sample width.
      function logic signed [SAMPLE_BITS-1:0] run_section(logic sec,
                                                          logic signed [SAMPLE_BITS-1:0] x);
         logic signed [SAMPLE_BITS-1:0] outer;
         logic signed [SAMPLE_BITS-1:0] y;
         outer = x + in_hist[sec][1];
         y = scale(outer, coef[CSR_FEED_0]) + scale(in_hist[sec][0], coef[CSR_FEED_1])
             - scale(out_hist[sec][0], coef[CSR_BACK_1])
             - scale(out_hist[sec][1], coef[CSR_BACK_2]);
         in_hist[sec][1]  = in_hist[sec][0];
         out_hist[sec][1] = out_hist[sec][0];
         in_hist[sec][0]  = x;
         out_hist[sec][0] = y;
         return y;
      endfunction

      function void accept_sample(logic op, logic signed [SAMPLE_BITS-1:0] sample);
         if (op == OP_PRIME) begin
            foreach (in_hist[s, t]) begin
               in_hist[s][t]  = sample;
               out_hist[s][t] = sample;
            end
            expected_filtered.push_back(sample);
            prime_count++;
         end else begin
            expected_filtered.push_back(run_section(SEC_SECOND, run_section(SEC_FIRST, sample)));
            filter_count++;
         end
      endfunction

      function void check_filtered(logic signed [SAMPLE_BITS-1:0] actual);
         logic signed [SAMPLE_BITS-1:0] expected;
         if (expected_filtered.size() == 0) begin
            $display("%0t: result %0d arrived with no item outstanding", $time, actual);
            mismatch_count++;
         end else begin
            expected = expected_filtered.pop_front();
            checked_count++;
            if (actual !== expected) begin
               $display("%0t: filtered mismatch, expected %0d, actual %0d",
                        $time, expected, actual);
               mismatch_count++;
            end
         end
      endfunction

      function int unsigned pending();
         return expected_filtered.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic                          req_operation = OP_PRIME;
   logic signed [SAMPLE_BITS-1:0] req_sample    = '0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered;
   logic                          csr_wr_en     = 1'b0;
   logic [1:0]                    csr_index     = CSR_FEED_0;
   logic [COEF_BITS-1:0]          csr_wdata     = '0;

   lowpass_scoreboard sb = new();

   stall_pattern_type stall_mode   = STALL_NONE;
   int unsigned       stall_run    = 0;
   int unsigned       burst_left   = 0;
   int unsigned       idle_cycles  = 0;
   int unsigned       coef_loads   = 0;

   cascaded_biquad_lowpass #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Note every accepted item and check every accepted result.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.accept_sample(req_operation, req_sample);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_filtered(rsp_filtered);
      end
   end

   // Receiver stall: each stretch picks a pattern, one of which never stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= STALL_NONE;
         stall_run  <= 0;
      end else begin
         if (stall_run == 0) begin
            stall_mode <= stall_pattern_type'($urandom_range(0, 2));
            stall_run  <= $urandom_range(50, 600);
         end else begin
            stall_run <= stall_run - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
            default:     rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one item, wait for it to be taken, then maybe pause the sender.
   task automatic send_item(logic op, logic signed [SAMPLE_BITS-1:0] sample);
      int unsigned gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_sample    <= sample;
      do @(posedge clock); while (req_stall);
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 40);
         burst_left = $urandom_range(1, 30);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Stop sending and wait until every expected result has been taken.
   // The first edge lets the monitor note an item taken at the edge just past.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write enable stays high across a run of writes; the caller lowers it.
   task automatic write_register(logic [1:0] index, coef_type value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_coef(index, value);
      @(posedge clock);
   endtask

   task automatic load_coefficients(coef_type feed_0, coef_type feed_1,
                                    coef_type back_1, coef_type back_2);
      write_register(CSR_FEED_0, feed_0);
      write_register(CSR_FEED_1, feed_1);
      write_register(CSR_BACK_1, back_1);
      write_register(CSR_BACK_2, back_2);
      csr_wr_en <= 1'b0;
      coef_loads++;
   endtask

   function automatic coef_type random_coef();
      return coef_type'($urandom_range(0, (1 << COEF_BITS) - 1));
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] next_sample(
         sample_style_type style, logic signed [SAMPLE_BITS-1:0] last);
      logic signed [SAMPLE_BITS-1:0] sample;
      case (style)
         STYLE_WALK:  sample = last + SAMPLE_BITS'($urandom_range(0, 16383)) - 8192;
         STYLE_NOISE: sample = $urandom();
         STYLE_STEP:  sample = last;
         default: begin
            case ($urandom_range(0, 4))
               0:       sample = SAMPLE_MAX;
               1:       sample = SAMPLE_MIN;
               2:       sample = '0;
               3:       sample = '1;
               default: sample = $urandom();
            endcase
         end
      endcase
      return sample;
   endfunction

   // Mostly a prime followed by a run of filter items; a few runs skip the
   // prime, and a stray prime now and then breaks a run.
   task automatic run_random(int unsigned count);
      int unsigned                   sent;
      int unsigned                   run_len;
      bit                            paused;
      sample_style_type              style;
      logic                          op;
      logic signed [SAMPLE_BITS-1:0] value;
      sent   = 0;
      paused = 1'b0;
      while (sent < count) begin
         style   = sample_style_type'($urandom_range(0, 3));
         run_len = $urandom_range(4, 40);
         value   = $urandom();
         if (style == STYLE_WALK || style == STYLE_STEP) value = value >>> 10;
         if ($urandom_range(0, 9) != 0) begin
            send_item(OP_PRIME, value);
            sent++;
         end
         if (style == STYLE_STEP) value = $signed(SAMPLE_BITS'($urandom())) >>> 10;
         repeat (run_len) begin
            op    = ($urandom_range(0, 49) == 0) ? OP_PRIME : OP_FILTER;
            value = next_sample(style, value);
            send_item(op, value);
            sent++;
         end
         // Let the filter empty completely once per phase.
         if (!paused && sent >= count / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end
      end
   endtask

   // Main sequence.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients are zero: filtering gives zero, priming echoes.
      send_item(OP_PRIME, SAMPLE_MAX);
      send_item(OP_FILTER, SAMPLE_MAX);
      send_item(OP_FILTER, SAMPLE_MIN);
      hold_until_drained();

      // A gentle low-pass: step response, extreme samples and wrap-around.
      load_coefficients(coef_type'(2212), coef_type'(4421),
                        coef_type'(-37453), coef_type'(13526));
      send_item(OP_PRIME, '0);
      repeat (5) send_item(OP_FILTER, Q15_ONE);
      send_item(OP_FILTER, SAMPLE_MAX);
      send_item(OP_FILTER, SAMPLE_MIN);
      send_item(OP_FILTER, '1);
      send_item(OP_FILTER, '0);
      send_item(OP_PRIME, SAMPLE_MIN);
      send_item(OP_FILTER, SAMPLE_MIN);
      send_item(OP_PRIME, SAMPLE_MAX);
      send_item(OP_FILTER, SAMPLE_MAX);
      send_item(OP_FILTER, 1);
      send_item(OP_PRIME, -Q15_ONE);
      run_random(PHASE_ITEMS);

      hold_until_drained();
      load_coefficients(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      run_random(PHASE_ITEMS);

      hold_until_drained();
      load_coefficients(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      run_random(PHASE_ITEMS);

      // A narrow low-pass whose poles sit close to the unit circle.
      hold_until_drained();
      load_coefficients(coef_type'(119), coef_type'(237),
                        coef_type'(-59727), coef_type'(27433));
      run_random(PHASE_ITEMS);

      hold_until_drained();
      load_coefficients(random_coef(), random_coef(), random_coef(), random_coef());
      run_random(PHASE_ITEMS);

      hold_until_drained();
      load_coefficients(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
      run_random(PHASE_ITEMS);

      // Let everything outstanding arrive, then watch for stray results.
      hold_until_drained();
      repeat (FINAL_CYCLES) @(posedge clock);

      $display("Run covered %0d prime and %0d filter items under %0d coefficient loads.",
               sb.prime_count, sb.filter_count, coef_loads);
      $display("%0d results checked, %0d mismatches, %0d still outstanding.",
               sb.checked_count, sb.mismatch_count, sb.pending());
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
